[rtl/core/tans_pkg.sv]
// Package for the tANS encoder: sizes, codes, controller states,
// command/status structs and small helper functions. No dependencies.
package tans_pkg;

    localparam int ALPHABET  = 256;
    localparam int MAX_LOG   = 12;
    localparam int LOG_MIN   = 5;
    localparam int SYM_W     = 8;
    localparam int LOG_W     = 4;
    localparam int ALPHA_W   = 9;
    localparam int CNT_W     = 13;
    localparam int ST_W      = MAX_LOG + 1;
    localparam int TBL_MAX   = 1 << MAX_LOG;
    localparam int TBL_AW    = MAX_LOG;
    localparam int STO_W     = 14;
    localparam int BOF_W     = 18;
    localparam int TOT_W     = 21;
    localparam int IDX_W     = 13;
    localparam int BITS_W    = 12;
    localparam int LOG_RST   = 11;
    localparam int ALPHA_RST = 256;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_ENCODE = 2'd2,
        OP_FINAL  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_ACK   = 2'd0,
        K_CHUNK = 2'd1,
        K_FINAL = 2'd2,
        K_ERROR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE = 2'd0,
        E_SUM  = 2'd1,
        E_SYM  = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        R_ACK,
        R_ESUM,
        R_ESYM,
        R_CHUNK,
        R_FINAL
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SUM_RD,
        S_SUM_ACC,
        S_CHECK,
        S_SPR_RD,
        S_SPR_Q,
        S_SPR_WR,
        S_OFF_RD,
        S_OFF_WR,
        S_TAB_RD,
        S_TAB_SYM,
        S_TAB_WR,
        S_FIN,
        S_ENC_IDX,
        S_ENC_ST,
        S_RES
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic idx_clr;
        logic idx_inc;
        logic tot_clr;
        logic tot_acc;
        logic spr_init;
        logic q_latch;
        logic rep_inc;
        logic spr_wr;
        logic off_wr;
        logic rd_tab;
        logic tsym_latch;
        logic tab_wr;
        logic enc_idx;
        logic enc_st;
        logic build_fin;
        logic pend_wr;
        t_res pend_sel;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic last_sum;
        logic sum_ok;
        logic rep_done;
        logic last_sym;
        logic last_slot;
        logic usable;
        logic out_free;
    } t_sts;

    function automatic logic [LOG_W-1:0] eff_log(input logic [LOG_W-1:0] v);
        if (v < LOG_W'(LOG_MIN))
            return LOG_W'(LOG_MIN);
        else if (v > LOG_W'(MAX_LOG))
            return LOG_W'(MAX_LOG);
        else
            return v;
    endfunction

    function automatic logic [ALPHA_W-1:0] eff_alpha(input logic [ALPHA_W-1:0] v);
        if (v == '0)
            return ALPHA_W'(1);
        else if (v > ALPHA_W'(ALPHABET))
            return ALPHA_W'(ALPHABET);
        else
            return v;
    endfunction

    // position of the highest set bit, zero for zero
    function automatic logic [LOG_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
        logic [LOG_W-1:0] e;
        e = '0;
        for (int b = 1; b < CNT_W; b++) begin
            if (v[b])
                e = LOG_W'(b);
        end
        return e;
    endfunction

endpackage

[rtl/core/tans_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tans_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/tans_ctrl.sv]
// Controller state machine of the tANS encoder: sequences load, build,
// encode and final items. Depends on tans_pkg.
module tans_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tans_pkg::t_sts    i_sts,
    output tans_pkg::t_cmd    o_cmd,
    output logic              o_in_stall,
    output tans_pkg::t_state  o_state
);

    tans_pkg::t_state r_state;
    tans_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= tans_pkg::S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.pend_sel = tans_pkg::R_ACK;
        case (r_state)
            tans_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = tans_pkg::S_DISPATCH;
                end
            end
            tans_pkg::S_DISPATCH: begin
                case (i_sts.op)
                    tans_pkg::OP_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                        o_cmd.pend_wr = 1'b1;
                        n_state = tans_pkg::S_RES;
                    end
                    tans_pkg::OP_BUILD: begin
                        o_cmd.idx_clr = 1'b1;
                        o_cmd.tot_clr = 1'b1;
                        n_state = tans_pkg::S_SUM_RD;
                    end
                    tans_pkg::OP_ENCODE: begin
                        n_state = tans_pkg::S_ENC_IDX;
                    end
                    default: begin
                        o_cmd.pend_wr  = 1'b1;
                        o_cmd.pend_sel = tans_pkg::R_FINAL;
                        n_state = tans_pkg::S_RES;
                    end
                endcase
            end
            tans_pkg::S_SUM_RD: n_state = tans_pkg::S_SUM_ACC;
            tans_pkg::S_SUM_ACC: begin
                o_cmd.tot_acc = 1'b1;
                if (i_sts.last_sum) begin
                    n_state = tans_pkg::S_CHECK;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = tans_pkg::S_SUM_RD;
                end
            end
            tans_pkg::S_CHECK: begin
                if (i_sts.sum_ok) begin
                    o_cmd.idx_clr  = 1'b1;
                    o_cmd.spr_init = 1'b1;
                    n_state = tans_pkg::S_SPR_RD;
                end else begin
                    o_cmd.pend_wr  = 1'b1;
                    o_cmd.pend_sel = tans_pkg::R_ESUM;
                    n_state = tans_pkg::S_RES;
                end
            end
            tans_pkg::S_SPR_RD: n_state = tans_pkg::S_SPR_Q;
            tans_pkg::S_SPR_Q: begin
                o_cmd.q_latch = 1'b1;
                n_state = tans_pkg::S_SPR_WR;
            end
            tans_pkg::S_SPR_WR: begin
                if (!i_sts.rep_done) begin
                    o_cmd.spr_wr  = 1'b1;
                    o_cmd.rep_inc = 1'b1;
                end else if (i_sts.last_sum) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = tans_pkg::S_OFF_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = tans_pkg::S_SPR_RD;
                end
            end
            tans_pkg::S_OFF_RD: n_state = tans_pkg::S_OFF_WR;
            tans_pkg::S_OFF_WR: begin
                o_cmd.off_wr = 1'b1;
                if (i_sts.last_sym) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = tans_pkg::S_TAB_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = tans_pkg::S_OFF_RD;
                end
            end
            tans_pkg::S_TAB_RD: n_state = tans_pkg::S_TAB_SYM;
            tans_pkg::S_TAB_SYM: begin
                o_cmd.rd_tab     = 1'b1;
                o_cmd.tsym_latch = 1'b1;
                n_state = tans_pkg::S_TAB_WR;
            end
            tans_pkg::S_TAB_WR: begin
                o_cmd.tab_wr = 1'b1;
                if (i_sts.last_slot) begin
                    n_state = tans_pkg::S_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = tans_pkg::S_TAB_RD;
                end
            end
            tans_pkg::S_FIN: begin
                o_cmd.build_fin = 1'b1;
                o_cmd.pend_wr   = 1'b1;
                n_state = tans_pkg::S_RES;
            end
            tans_pkg::S_ENC_IDX: begin
                if (i_sts.usable) begin
                    o_cmd.enc_idx = 1'b1;
                    n_state = tans_pkg::S_ENC_ST;
                end else begin
                    o_cmd.pend_wr  = 1'b1;
                    o_cmd.pend_sel = tans_pkg::R_ESYM;
                    n_state = tans_pkg::S_RES;
                end
            end
            tans_pkg::S_ENC_ST: begin
                o_cmd.enc_st   = 1'b1;
                o_cmd.pend_wr  = 1'b1;
                o_cmd.pend_sel = tans_pkg::R_CHUNK;
                n_state = tans_pkg::S_RES;
            end
            tans_pkg::S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = tans_pkg::S_IDLE;
                end
            end
            default: n_state = tans_pkg::S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != tans_pkg::S_IDLE);
    assign o_state    = r_state;

endmodule

[rtl/core/tans_dp.sv]
// Datapath of the tANS encoder: count, offset, spread and encoding
// memories, build counters, coder state and result register.
// Depends on tans_pkg and tans_ram.
module tans_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tans_pkg::t_cmd                 i_cmd,
    output tans_pkg::t_sts                 o_sts,
    input  logic [1:0]                     i_opcode,
    input  logic [tans_pkg::SYM_W-1:0]     i_symbol,
    input  logic [tans_pkg::CNT_W-1:0]     i_count,
    input  logic [tans_pkg::LOG_W-1:0]     i_table_log,
    input  logic [tans_pkg::ALPHA_W-1:0]   i_alpha,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [1:0]                     o_kind,
    output logic [tans_pkg::BITS_W-1:0]    o_bits,
    output logic [tans_pkg::LOG_W-1:0]     o_nbits,
    output logic [tans_pkg::ST_W-1:0]      o_final_state,
    output logic [1:0]                     o_error_code
);

    localparam int SYM_W  = tans_pkg::SYM_W;
    localparam int LOG_W  = tans_pkg::LOG_W;
    localparam int CNT_W  = tans_pkg::CNT_W;
    localparam int ST_W   = tans_pkg::ST_W;
    localparam int AW     = tans_pkg::TBL_AW;
    localparam int STO_W  = tans_pkg::STO_W;
    localparam int BOF_W  = tans_pkg::BOF_W;
    localparam int TOT_W  = tans_pkg::TOT_W;
    localparam int IDX_W  = tans_pkg::IDX_W;
    localparam int BITS_W = tans_pkg::BITS_W;
    localparam int ALPHA_W = tans_pkg::ALPHA_W;

    // captured item
    tans_pkg::t_op        r_op;
    logic [SYM_W-1:0]     r_sym;
    logic [CNT_W-1:0]     r_cnt;

    // build counters
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_rep;
    logic [CNT_W-1:0]     r_q;
    logic [AW-1:0]        r_pos;
    logic [TOT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_acc;
    logic [SYM_W-1:0]     r_tsym;

    logic [tans_pkg::ALPHABET-1:0] r_cnt_vld;
    logic [tans_pkg::ALPHABET-1:0] r_use;
    logic                 r_cvld;

    logic [ST_W-1:0]      r_state;
    logic [LOG_W-1:0]     r_built_log;
    logic [LOG_W-1:0]     r_nb;
    logic [BITS_W-1:0]    r_chunk;

    // pending and output result
    tans_pkg::t_kind      r_p_kind;
    logic [BITS_W-1:0]    r_p_bits;
    logic [LOG_W-1:0]     r_p_nbits;
    logic [ST_W-1:0]      r_p_fin;
    tans_pkg::t_err       r_p_err;
    logic                 r_ovld;
    tans_pkg::t_kind      r_o_kind;
    logic [BITS_W-1:0]    r_o_bits;
    logic [LOG_W-1:0]     r_o_nbits;
    logic [ST_W-1:0]      r_o_fin;
    tans_pkg::t_err       r_o_err;

    logic [LOG_W-1:0]     lg;
    logic [ST_W-1:0]      size;
    logic [AW-1:0]        mask;
    logic [AW-1:0]        step;
    logic [ALPHA_W-1:0]   na;
    logic [AW-1:0]        bmask;

    logic [CNT_W-1:0]     cnt_rd;
    logic [CNT_W-1:0]     cnt_q;
    logic [STO_W-1:0]     sto_rd;
    logic [BOF_W-1:0]     bof_rd;
    logic [CNT_W-1:0]     nxt_rd;
    logic [SYM_W-1:0]     spr_rd;
    logic [ST_W-1:0]      enc_rd;

    logic [CNT_W-1:0]     off_q;
    logic [LOG_W-1:0]     off_k;
    logic [BOF_W-1:0]     off_bof;
    logic [STO_W-1:0]     off_sto;

    logic [SYM_W-1:0]     sym_raddr;
    logic [SYM_W-1:0]     sym_waddr;
    logic [CNT_W-1:0]     nxt_wdata;
    logic [STO_W-1:0]     tab_sum;

    logic signed [BOF_W:0] esum;
    logic [BOF_W:0]       esum_pos;
    logic [BOF_W:0]       nb_wide;
    logic [LOG_W-1:0]     enc_nb;
    logic [ST_W-1:0]      enc_chunk;
    logic [STO_W-1:0]     enc_sum;
    logic [AW-1:0]        enc_raddr;

    always_comb begin
        lg    = tans_pkg::eff_log(i_table_log);
        size  = ST_W'(1) << lg;
        mask  = size[AW-1:0] - AW'(1);
        step  = AW'((size >> 1) + (size >> 3) + ST_W'(3));
        na    = tans_pkg::eff_alpha(i_alpha);
        bmask = AW'((ST_W'(1) << r_built_log) - ST_W'(1));
    end

    assign cnt_q = r_cvld ? cnt_rd : '0;

    // per-symbol offsets for the current symbol of the offset pass
    always_comb begin
        off_q   = (r_idx < IDX_W'(na)) ? cnt_q : '0;
        off_k   = lg - tans_pkg::floor_log2(off_q);
        off_bof = (off_q != '0)
                ? ((BOF_W'(off_k) << (lg + LOG_W'(1))) - (BOF_W'(off_q) << off_k))
                : '0;
        off_sto = STO_W'(r_acc) - STO_W'(off_q);
    end

    assign sym_raddr = i_cmd.rd_tab ? spr_rd : r_sym;
    assign sym_waddr = i_cmd.off_wr ? r_idx[SYM_W-1:0] : r_tsym;
    assign nxt_wdata = i_cmd.off_wr ? off_q : nxt_rd + CNT_W'(1);
    assign tab_sum   = sto_rd + STO_W'(nxt_rd);

    // encode step: bit count, chunk and next table index
    always_comb begin
        esum     = $signed({{(BOF_W + 1 - ST_W){1'b0}}, r_state})
                 + $signed({bof_rd[BOF_W-1], bof_rd});
        esum_pos = esum[BOF_W] ? '0 : esum;
        nb_wide  = esum_pos >> (r_built_log + LOG_W'(1));
        enc_nb   = (nb_wide > (BOF_W + 1)'(r_built_log)) ? r_built_log : nb_wide[LOG_W-1:0];
        enc_chunk = r_state & ((ST_W'(1) << enc_nb) - ST_W'(1));
        enc_sum  = sto_rd + STO_W'(r_state >> enc_nb);
        enc_raddr = enc_sum[AW-1:0] & bmask;
    end

    tans_ram #(.WIDTH(CNT_W), .DEPTH(tans_pkg::ALPHABET)) u_counts (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr),
        .i_waddr (r_sym),
        .i_wdata (r_cnt),
        .i_raddr (r_idx[SYM_W-1:0]),
        .o_rdata (cnt_rd)
    );

    tans_ram #(.WIDTH(STO_W), .DEPTH(tans_pkg::ALPHABET)) u_start (
        .i_clk   (i_clk),
        .i_we    (i_cmd.off_wr),
        .i_waddr (sym_waddr),
        .i_wdata (off_sto),
        .i_raddr (sym_raddr),
        .o_rdata (sto_rd)
    );

    tans_ram #(.WIDTH(BOF_W), .DEPTH(tans_pkg::ALPHABET)) u_bitoff (
        .i_clk   (i_clk),
        .i_we    (i_cmd.off_wr),
        .i_waddr (sym_waddr),
        .i_wdata (off_bof),
        .i_raddr (r_sym),
        .o_rdata (bof_rd)
    );

    tans_ram #(.WIDTH(CNT_W), .DEPTH(tans_pkg::ALPHABET)) u_next (
        .i_clk   (i_clk),
        .i_we    (i_cmd.off_wr | i_cmd.tab_wr),
        .i_waddr (sym_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (sym_raddr),
        .o_rdata (nxt_rd)
    );

    tans_ram #(.WIDTH(SYM_W), .DEPTH(tans_pkg::TBL_MAX)) u_spread (
        .i_clk   (i_clk),
        .i_we    (i_cmd.spr_wr),
        .i_waddr (r_pos),
        .i_wdata (r_idx[SYM_W-1:0]),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (spr_rd)
    );

    tans_ram #(.WIDTH(ST_W), .DEPTH(tans_pkg::TBL_MAX)) u_enc (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tab_wr),
        .i_waddr (tab_sum[AW-1:0] & mask),
        .i_wdata (size + r_idx),
        .i_raddr (enc_raddr),
        .o_rdata (enc_rd)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cvld <= r_cnt_vld[r_idx[SYM_W-1:0]];
        if (i_cmd.capture) begin
            r_op  <= tans_pkg::t_op'(i_opcode);
            r_sym <= i_symbol;
            r_cnt <= i_count;
        end
        if (i_cmd.idx_clr)
            r_idx <= '0;
        else if (i_cmd.idx_inc)
            r_idx <= r_idx + IDX_W'(1);
        if (i_cmd.tot_clr)
            r_total <= '0;
        else if (i_cmd.tot_acc)
            r_total <= r_total + TOT_W'(cnt_q);
        if (i_cmd.spr_init) begin
            r_pos <= '0;
            r_acc <= '0;
        end else begin
            if (i_cmd.spr_wr)
                r_pos <= (r_pos + step) & mask;
            if (i_cmd.off_wr)
                r_acc <= r_acc + off_q;
        end
        if (i_cmd.q_latch) begin
            r_q   <= cnt_q;
            r_rep <= '0;
        end else if (i_cmd.rep_inc) begin
            r_rep <= r_rep + CNT_W'(1);
        end
        if (i_cmd.tsym_latch)
            r_tsym <= spr_rd;
        if (i_cmd.enc_idx) begin
            r_nb    <= enc_nb;
            r_chunk <= enc_chunk[BITS_W-1:0];
        end
        if (i_cmd.pend_wr) begin
            case (i_cmd.pend_sel)
                tans_pkg::R_ESUM: begin
                    r_p_kind  <= tans_pkg::K_ERROR;
                    r_p_bits  <= '0;
                    r_p_nbits <= '0;
                    r_p_fin   <= '0;
                    r_p_err   <= tans_pkg::E_SUM;
                end
                tans_pkg::R_ESYM: begin
                    r_p_kind  <= tans_pkg::K_ERROR;
                    r_p_bits  <= '0;
                    r_p_nbits <= '0;
                    r_p_fin   <= '0;
                    r_p_err   <= tans_pkg::E_SYM;
                end
                tans_pkg::R_CHUNK: begin
                    r_p_kind  <= tans_pkg::K_CHUNK;
                    r_p_bits  <= r_chunk;
                    r_p_nbits <= r_nb;
                    r_p_fin   <= '0;
                    r_p_err   <= tans_pkg::E_NONE;
                end
                tans_pkg::R_FINAL: begin
                    r_p_kind  <= tans_pkg::K_FINAL;
                    r_p_bits  <= '0;
                    r_p_nbits <= '0;
                    r_p_fin   <= r_state;
                    r_p_err   <= tans_pkg::E_NONE;
                end
                default: begin
                    r_p_kind  <= tans_pkg::K_ACK;
                    r_p_bits  <= '0;
                    r_p_nbits <= '0;
                    r_p_fin   <= '0;
                    r_p_err   <= tans_pkg::E_NONE;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_kind  <= r_p_kind;
            r_o_bits  <= r_p_bits;
            r_o_nbits <= r_p_nbits;
            r_o_fin   <= r_p_fin;
            r_o_err   <= r_p_err;
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld   <= '0;
            r_use       <= '0;
            r_built_log <= tans_pkg::eff_log(LOG_W'(tans_pkg::LOG_RST));
            r_state     <= (ST_W'(1) << tans_pkg::eff_log(LOG_W'(tans_pkg::LOG_RST)))
                         + ST_W'(1);
            r_ovld      <= 1'b0;
        end else begin
            if (i_cmd.load_wr)
                r_cnt_vld[r_sym] <= 1'b1;
            if (i_cmd.off_wr)
                r_use[r_idx[SYM_W-1:0]] <= (off_q != '0);
            if (i_cmd.build_fin) begin
                r_built_log <= lg;
                r_state     <= size + ST_W'(1);
            end else if (i_cmd.enc_st) begin
                r_state <= enc_rd;
            end
            if (i_cmd.out_load)
                r_ovld <= 1'b1;
            else if (!i_out_stall)
                r_ovld <= 1'b0;
        end
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.last_sum  = (r_idx == IDX_W'(na) - IDX_W'(1));
        o_sts.sum_ok    = (r_total == TOT_W'(size));
        o_sts.rep_done  = (r_rep == r_q);
        o_sts.last_sym  = (r_idx == IDX_W'(tans_pkg::ALPHABET - 1));
        o_sts.last_slot = (r_idx == size - ST_W'(1));
        o_sts.usable    = r_use[r_sym];
        o_sts.out_free  = !r_ovld || !i_out_stall;
    end

    assign o_out_valid   = r_ovld;
    assign o_kind        = r_o_kind;
    assign o_bits        = r_o_bits;
    assign o_nbits       = r_o_nbits;
    assign o_final_state = r_o_fin;
    assign o_error_code  = r_o_err;

endmodule

[rtl/core/tans_encoder.sv]
// Top level of the tANS encoder: APB configuration registers, controller
// and datapath. Depends on tans_pkg, tans_ctrl, tans_dp (and tans_ram).
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+----------------------------------
//  input    | i_in_valid / o_in_stall        | i_opcode i_symbol i_count
//  result   | o_out_valid / i_out_stall      | o_kind o_bits o_nbits
//           |                                | o_final_state o_error_code
//  config   | psel penable pwrite pready     | paddr pwdata prdata
//
// One item at a time. Load and final go from dispatch straight to the result
// register. Encode reads the offsets and then the encoding table addressed
// from the coder state; an unusable symbol ends before the table read. Build
// time is set by the memory sweeps over the counts, spread, offsets and slots;
// a bad sum ends after the sum sweep.
// Reset is synchronous; counts read as zero until loaded.
// A stalled result holds in the output register; the next item is taken as
// soon as its result has moved there.
module tans_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [tans_pkg::SYM_W-1:0]    i_symbol,
    input  logic [tans_pkg::CNT_W-1:0]    i_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_kind,
    output logic [tans_pkg::BITS_W-1:0]   o_bits,
    output logic [tans_pkg::LOG_W-1:0]    o_nbits,
    output logic [tans_pkg::ST_W-1:0]     o_final_state,
    output logic [1:0]                    o_error_code,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [tans_pkg::LOG_W-1:0]   r_table_log;
    logic [tans_pkg::ALPHA_W-1:0] r_alpha;
    logic                         cfg_wr;
    tans_pkg::t_cmd               cmd;
    tans_pkg::t_sts               sts;
    tans_pkg::t_state             ctrl_state;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_log <= tans_pkg::LOG_W'(tans_pkg::LOG_RST);
            r_alpha     <= tans_pkg::ALPHA_W'(tans_pkg::ALPHA_RST);
        end else if (cfg_wr) begin
            if (paddr[2])
                r_alpha <= pwdata[tans_pkg::ALPHA_W-1:0];
            else
                r_table_log <= pwdata[tans_pkg::LOG_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'(r_alpha) : 32'(r_table_log);

    tans_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall),
        .o_state    (ctrl_state)
    );

    tans_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_symbol      (i_symbol),
        .i_count       (i_count),
        .i_table_log   (r_table_log),
        .i_alpha       (r_alpha),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_bits        (o_bits),
        .o_nbits       (o_nbits),
        .o_final_state (o_final_state),
        .o_error_code  (o_error_code)
    );

    // an accepted item always goes straight to dispatch
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (ctrl_state == tans_pkg::S_DISPATCH))
        else $error("accepted item not dispatched");

    // a result is never moved into a full, stalled output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result overwrote a stalled item");

    // dispatch is only ever entered from an accepted item
    a_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl_state == tans_pkg::S_DISPATCH) |-> $past(i_in_valid && !o_in_stall))
        else $error("dispatch without accepted item");

endmodule

[tb/tans_checker.sv]
// Checker for the tANS encoder: watches the item, result and APB channels,
// keeps its own copy of the coder tables and compares every result.
// Depends on tans_pkg.
`timescale 1ns / 100ps

module tans_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [tans_pkg::SYM_W-1:0]    i_symbol,
    input  logic [tans_pkg::CNT_W-1:0]    i_count,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [1:0]                    i_kind,
    input  logic [tans_pkg::BITS_W-1:0]   i_bits,
    input  logic [tans_pkg::LOG_W-1:0]    i_nbits,
    input  logic [tans_pkg::ST_W-1:0]     i_final_state,
    input  logic [1:0]                    i_error_code,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [2:0]                    i_paddr,
    input  logic [31:0]                   i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        tans_pkg::t_kind                kind;
        logic [tans_pkg::BITS_W-1:0]    bits;
        logic [tans_pkg::LOG_W-1:0]     nbits;
        logic [tans_pkg::ST_W-1:0]      fin;
        tans_pkg::t_err                 err;
    } t_coder_result;

    t_coder_result result_q[$];

    logic [3:0] log_reg;
    logic [8:0] alpha_reg;
    int         sym_count [tans_pkg::ALPHABET];
    int         start_off [tans_pkg::ALPHABET];
    int         bit_off   [tans_pkg::ALPHABET];
    int         next_cnt  [tans_pkg::ALPHABET];
    bit         sym_ok    [tans_pkg::ALPHABET];
    int         slot_sym  [tans_pkg::TBL_MAX];
    int         enc_tab   [tans_pkg::TBL_MAX];
    int         coder;
    int         built_log;
    int         fails;

    assign o_fail_count = fails;
    assign o_pending    = result_q.size();

    function automatic int clamp_log(input logic [3:0] v);
        if (v < tans_pkg::LOG_MIN) return tans_pkg::LOG_MIN;
        if (v > tans_pkg::MAX_LOG) return tans_pkg::MAX_LOG;
        return int'(v);
    endfunction

    function automatic int clamp_alpha(input logic [8:0] v);
        if (v == 0) return 1;
        if (v > tans_pkg::ALPHABET) return tans_pkg::ALPHABET;
        return int'(v);
    endfunction

    function automatic int msb_pos(input int v);
        int e;
        e = 0;
        while (v > 1) begin
            v = v >> 1;
            e++;
        end
        return e;
    endfunction

    function automatic t_coder_result build_tables();
        t_coder_result r;
        int lg, size, mask, na, total, pos, acc, step, q, k, sym, idx;
        r = '0;
        lg = clamp_log(log_reg);
        size = 1 << lg;
        mask = size - 1;
        na = clamp_alpha(alpha_reg);
        total = 0;
        for (int s = 0; s < na; s++) total += sym_count[s];
        if (total != size) begin
            r.kind = tans_pkg::K_ERROR;
            r.err  = tans_pkg::E_SUM;
            return r;
        end
        step = size * 5 / 8 + 3;
        pos = 0;
        for (int s = 0; s < na; s++)
            for (int i = 0; i < sym_count[s]; i++) begin
                slot_sym[pos & mask] = s;
                pos = (pos + step) & mask;
            end
        acc = 0;
        for (int s = 0; s < tans_pkg::ALPHABET; s++) begin
            q = (s < na) ? sym_count[s] : 0;
            sym_ok[s] = (q != 0);
            if (q != 0) begin
                k = lg - msb_pos(q);
                bit_off[s] = (k << (lg + 1)) - (q << k);
            end else begin
                bit_off[s] = 0;
            end
            start_off[s] = acc - q;
            acc += q;
            next_cnt[s] = q;
        end
        for (int x = size; x < 2 * size; x++) begin
            sym = slot_sym[x - size];
            idx = start_off[sym] + next_cnt[sym];
            enc_tab[idx & mask] = x;
            next_cnt[sym]++;
        end
        built_log = lg;
        coder = size + 1;
        r.kind = tans_pkg::K_ACK;
        return r;
    endfunction

    function automatic t_coder_result encode_symbol(input int s);
        t_coder_result r;
        int sum, nb, mask;
        r = '0;
        if (!sym_ok[s]) begin
            r.kind = tans_pkg::K_ERROR;
            r.err  = tans_pkg::E_SYM;
            return r;
        end
        mask = (1 << built_log) - 1;
        sum = coder + bit_off[s];
        if (sum < 0) sum = 0;
        nb = sum >> (built_log + 1);
        if (nb > built_log) nb = built_log;
        r.kind  = tans_pkg::K_CHUNK;
        r.bits  = tans_pkg::BITS_W'(coder & ((1 << nb) - 1));
        r.nbits = tans_pkg::LOG_W'(nb);
        coder = enc_tab[(start_off[s] + (coder >> nb)) & mask];
        return r;
    endfunction

    function automatic t_coder_result next_result(input tans_pkg::t_op op, input int s,
                                                  input int c);
        t_coder_result r;
        r = '0;
        case (op)
            tans_pkg::OP_LOAD: begin
                sym_count[s] = c;
                r.kind = tans_pkg::K_ACK;
            end
            tans_pkg::OP_BUILD:  r = build_tables();
            tans_pkg::OP_ENCODE: r = encode_symbol(s);
            default: begin
                r.kind = tans_pkg::K_FINAL;
                r.fin  = tans_pkg::ST_W'(coder);
            end
        endcase
        return r;
    endfunction

    initial fails = 0;

    always @(posedge i_clk) begin
        t_coder_result e;
        if (!i_rst_n) begin
            log_reg   <= 4'(tans_pkg::LOG_RST);
            alpha_reg <= 9'(tans_pkg::ALPHA_RST);
            for (int s = 0; s < tans_pkg::ALPHABET; s++) begin
                sym_count[s] = 0;
                sym_ok[s] = 0;
            end
            built_log = tans_pkg::LOG_RST;
            coder = (1 << tans_pkg::LOG_RST) + 1;
            result_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == 1'b0) log_reg <= i_pwdata[3:0];
                else                    alpha_reg <= i_pwdata[8:0];
            end
            if (i_in_valid && !i_in_stall)
                result_q.push_back(next_result(tans_pkg::t_op'(i_opcode), i_symbol,
                                               i_count));
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result with none expected: kind %0d", i_kind);
                    fails++;
                end else begin
                    e = result_q.pop_front();
                    if (i_kind !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, i_kind);
                        fails++;
                    end
                    if (i_bits !== e.bits) begin
                        $error("bits: expected %0h, got %0h", e.bits, i_bits);
                        fails++;
                    end
                    if (i_nbits !== e.nbits) begin
                        $error("nbits: expected %0d, got %0d", e.nbits, i_nbits);
                        fails++;
                    end
                    if (i_final_state !== e.fin) begin
                        $error("final_state: expected %0d, got %0d", e.fin, i_final_state);
                        fails++;
                    end
                    if (i_error_code !== e.err) begin
                        $error("error_code: expected %0d, got %0d", e.err, i_error_code);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

[tb/tb_top.sv]
// Top of the tANS encoder testbench: clock, reset, item and APB stimulus,
// result-side stalls and the verdict. Depends on tans_pkg, tans_encoder and
// tans_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int N_ITEMS   = 1550;
    localparam int MAX_CYCLE = 2000000;
    localparam int ADDR_LOG  = 0;
    localparam int ADDR_ALPHA = 4;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [1:0]                   i_opcode = tans_pkg::OP_LOAD;
    logic [tans_pkg::SYM_W-1:0]   i_symbol = '0;
    logic [tans_pkg::CNT_W-1:0]   i_count = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [1:0]                   o_kind;
    logic [tans_pkg::BITS_W-1:0]  o_bits;
    logic [tans_pkg::LOG_W-1:0]   o_nbits;
    logic [tans_pkg::ST_W-1:0]    o_final_state;
    logic [1:0]                   o_error_code;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [2:0]                   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    int fail_count;
    int pending;
    int n_sent = 0;
    int n_builds = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold_done = 0;
    int hold_left = 0;
    int burst_left = 0;

    tans_encoder DUT (.*);

    tans_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_symbol(i_symbol), .i_count(i_count),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_kind(o_kind), .i_bits(o_bits), .i_nbits(o_nbits),
        .i_final_state(o_final_state), .i_error_code(o_error_code),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("** tans_encoder: FAILED **");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold to back the block up
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && n_sent >= 250) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            burst_left <= $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send(input tans_pkg::t_op op, input int s, input int c);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_symbol   <= tans_pkg::SYM_W'(s);
        i_count    <= tans_pkg::CNT_W'(c);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        quiet = (n_sent >= N_ITEMS - 200);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // stop offering items and let every outstanding result drain
    task automatic drain();
        if (i_in_valid) i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apb_write(input int addr, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(addr);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // one coding session: configure, load counts summing to the table size,
    // build (sometimes after a failed build), encode, read the state
    task automatic run_session(input int log_raw, input int alpha_raw, input int n_enc);
        int lg, na, size, rem, cap, c, r, s;
        int cnt[tans_pkg::ALPHABET];
        int live[$];
        drain();
        apb_write(ADDR_LOG, log_raw);
        apb_write(ADDR_ALPHA, alpha_raw);
        lg = (log_raw < tans_pkg::LOG_MIN) ? tans_pkg::LOG_MIN
           : (log_raw > tans_pkg::MAX_LOG) ? tans_pkg::MAX_LOG : log_raw;
        na = (alpha_raw == 0) ? 1
           : (alpha_raw > tans_pkg::ALPHABET) ? tans_pkg::ALPHABET : alpha_raw;
        size = 1 << lg;
        rem = size;
        cap = 2 * size / na + 1;
        for (int i = 0; i < na; i++) begin
            if (i == na - 1) c = rem;
            else if (rem == 0 || $urandom_range(0, 3) == 0) c = 0;
            else c = $urandom_range(1, (rem < cap) ? rem : cap);
            cnt[i] = c;
            rem -= c;
            if (c != 0) live.push_back(i);
            send(tans_pkg::OP_LOAD, i, c);
        end
        if (na < tans_pkg::ALPHABET)
            repeat ($urandom_range(0, 2))
                send(tans_pkg::OP_LOAD, $urandom_range(na, tans_pkg::ALPHABET - 1),
                     $urandom_range(0, 8191));
        if ($urandom_range(0, 3) == 0) begin
            send(tans_pkg::OP_LOAD, 0, cnt[0] + 1);
            send(tans_pkg::OP_BUILD, 0, 0);
            send(tans_pkg::OP_LOAD, 0, cnt[0]);
        end
        send(tans_pkg::OP_BUILD, $urandom_range(0, 255), $urandom_range(0, 8191));
        n_builds++;
        for (int i = 0; i < n_enc; i++) begin
            r = $urandom_range(0, 19);
            if (r < 16) s = live[$urandom_range(0, live.size() - 1)];
            else s = $urandom_range(0, 255);
            send((r == 19) ? tans_pkg::OP_FINAL : tans_pkg::OP_ENCODE, s,
                 $urandom_range(0, 8191));
        end
        send(tans_pkg::OP_FINAL, 0, 0);
    endtask

    initial begin
        int r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // state after reset, encode with no tables, a build with a bad sum
        send(tans_pkg::OP_FINAL, 0, 0);
        send(tans_pkg::OP_ENCODE, 5, 0);
        send(tans_pkg::OP_LOAD, 255, 8191);
        send(tans_pkg::OP_LOAD, 0, 0);
        send(tans_pkg::OP_BUILD, 0, 0);
        // registers below range saturate: 32-slot table, one symbol
        drain();
        apb_write(ADDR_LOG, 0);
        apb_write(ADDR_ALPHA, 0);
        send(tans_pkg::OP_LOAD, 0, 32);
        send(tans_pkg::OP_BUILD, 0, 0);
        n_builds++;
        repeat (3) send(tans_pkg::OP_ENCODE, 0, 0);
        send(tans_pkg::OP_ENCODE, 1, 0);
        send(tans_pkg::OP_ENCODE, 255, 0);
        send(tans_pkg::OP_FINAL, 0, 0);
        // new registers do not touch the tables already built
        drain();
        apb_write(ADDR_LOG, 15);
        apb_write(ADDR_ALPHA, 511);
        send(tans_pkg::OP_ENCODE, 0, 0);
        send(tans_pkg::OP_ENCODE, 0, 0);
        send(tans_pkg::OP_FINAL, 0, 0);
        run_session(15, 511, 40);
        run_session(12, 1, 20);

        while (n_sent < N_ITEMS) begin
            r = $urandom_range(0, 24);
            if (r == 0)
                run_session($urandom_range(12, 15), $urandom_range(200, 511),
                            $urandom_range(20, 60));
            else if (r < 4)
                run_session($urandom_range(9, 11), $urandom_range(2, 64),
                            $urandom_range(20, 80));
            else
                run_session($urandom_range(0, 8), $urandom_range(1, 20),
                            $urandom_range(20, 80));
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d items and %0d table builds over table sizes 32 to 4096,",
                 n_sent, n_builds);
        $display("with bad sums, unusable symbols and register changes after a build.");
        if (fail_count == 0 && pending == 0) begin
            $display("** tans_encoder: PASSED **");
        end else begin
            $display("** tans_encoder: FAILED **");
        end
        $finish;
    end

endmodule
